// ----- design/scalar_kalman_filter_assert.svh -----
// Assertion helpers shared by the filter modules.
// Each macro expects signals named clk and rst in the including scope.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define SKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define SKF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/skf_pkg.sv -----
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 16;

  localparam int DATA_W = 32;
  localparam int GAIN_W = GAIN_BITS + 1;
  localparam int DEN_W  = DATA_W + 1;
  localparam int REM_W  = DATA_W + 2;
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = DATA_W + 2;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int SHIFT_W = PROD_W - GAIN_BITS;
  localparam int EST_SUM_W = SHIFT_W + 1;

  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 88;

  localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] Q_RESET = DATA_W'((64'd1 << FRAC_BITS) / 100);
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'd1 << GAIN_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIOR,
    ST_DEN,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_VAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic idle;
    logic prior_en;
    logic div_start;
    logic gain_en;
    logic mul_en;
    logic mul_var_sel;
    logic est_en;
    logic commit;
  } ctl_t;

  // Saturate a 33-bit signed sum to 32 bits.
  function automatic logic [DATA_W-1:0] sat_s33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 33-bit unsigned sum to 32 bits.
  function automatic logic [DATA_W-1:0] sat_u33(input logic [DATA_W:0] v);
    return v[DATA_W] ? {DATA_W{1'b1}} : v[DATA_W-1:0];
  endfunction

  // Saturate the wide signed estimate sum to 32 bits.
  function automatic logic [DATA_W-1:0] sat_est(input logic [EST_SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    logic [EST_SUM_W-DATA_W:0] top;
    top = v[EST_SUM_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[EST_SUM_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/skf_div.sv -----
`include "scalar_kalman_filter_assert.svh"

// Restoring divider: quo = floor(num * 2^GAIN_BITS / den), one quotient bit a cycle.
// num must not exceed den, so the quotient fits in GAIN_W bits.
module skf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [skf_pkg::DATA_W-1:0] num,
  input  logic [skf_pkg::DEN_W-1:0]  den,
  output logic                      done,
  output logic [skf_pkg::GAIN_W-1:0] quo
);
  import skf_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic              den_zero;
  logic [GAIN_W-1:0] quo_q;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [REM_W-1:0]  rem_next;

  assign diff = {1'b0, rem} - (REM_W+1)'(den_q);
  assign ge = !diff[REM_W];
  assign rem_next = ge ? diff[REM_W-1:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(num);
      den_q    <= den;
      den_zero <= (den == '0);
      quo_q    <= '0;
    end else if (busy) begin
      rem   <= {rem_next[REM_W-2:0], 1'b0};
      quo_q <= {quo_q[GAIN_W-2:0], ge};
    end
  end

  // A zero denominator gives a zero gain.
  assign quo = den_zero ? '0 : quo_q;

  `SKF_NEVER(a_div_restart_busy, start && busy, "divider started while busy")
  `SKF_ASSERT(a_div_done_pulse, done |=> !done, "divider done longer than one cycle")
  `SKF_ASSERT(a_div_quo_range, done |-> (quo <= GAIN_ONE), "gain above one")

endmodule

// ----- design/skf_seq.sv -----
`include "scalar_kalman_filter_assert.svh"

module skf_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_accept,
  input  logic          div_done,
  input  logic          out_free,
  output skf_pkg::ctl_t ctl
);
  import skf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_accept) state_next = ST_PRIOR;
      ST_PRIOR:   state_next = ST_DEN;
      ST_DEN:     state_next = ST_DIV;
      ST_DIV:     if (div_done) state_next = ST_MUL_EST;
      ST_MUL_EST: state_next = ST_MUL_VAR;
      ST_MUL_VAR: state_next = ST_FINISH;
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE:    ctl.idle = 1'b1;
      ST_PRIOR:   ctl.prior_en = 1'b1;
      ST_DEN:     ctl.div_start = 1'b1;
      ST_DIV:     ctl.gain_en = div_done;
      ST_MUL_EST: ctl.mul_en = 1'b1;
      ST_MUL_VAR: begin
        ctl.mul_en      = 1'b1;
        ctl.mul_var_sel = 1'b1;
        ctl.est_en      = 1'b1;
      end
      ST_FINISH:  ctl.commit = out_free;
      default:    ctl = '0;
    endcase
  end

  `SKF_ASSERT(a_seq_done_in_div, div_done |-> (state == ST_DIV), "divide result out of step")
  `SKF_ASSERT(a_seq_accept_starts, in_accept |=> (state == ST_PRIOR), "accepted item not started")
  `SKF_ASSERT(a_seq_commit_ends, ctl.commit |=> ctl.idle, "sequencer not idle after commit")

endmodule

// ----- design/scalar_kalman_filter.sv -----
// Scalar Kalman filter, Q16.16 data, Q1.16 gain.
// Input channel s_axis: tdata carries measurement and control offset, tuser
// the restart flag, which reloads estimate and variance from init_estimate
// and init_variance before the step. Output channel m_axis: one item per input
// with the new estimate, new variance and the gain used.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..3 selecting process noise,
// measurement noise, initial estimate and initial variance; other indexes are
// ignored. cfg_ready is always high; write only while no item is in flight.
// Sequence: after acceptance an item passes the prior and the denominator states,
// the bit-serial divider that forms the gain (one quotient bit a cycle), then
// two passes through the shared 18x34 multiplier and the commit state.
// s_axis_tready is high only while the sequencer is idle, so a new item is
// taken only after the previous one has committed.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and computed, and waits in its commit state until
// the output register is free.
// Reset clears estimate to 0, variance to 1.0 and the registers to their
// defaults (q = 1/100, r = 1.0, initial estimate 0, initial variance 1.0).
`include "scalar_kalman_filter_assert.svh"

module scalar_kalman_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // measurement [31:0], control_offset [63:32]
  input  logic [skf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // restart
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_estimate [31:0], new_variance [63:32], gain [80:64], zeros above
  output logic [skf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]     cfg_data
);
  import skf_pkg::*;

  ctl_t ctl;

  logic [DATA_W-1:0] process_noise, measure_noise, init_estimate, init_variance;
  logic [DATA_W-1:0] estimate_reg, variance_reg;

  logic [DATA_W-1:0] meas, ctrl_off;
  logic              restart;

  logic [DATA_W-1:0]  prior, pvar;
  logic [DATA_W-1:0]  est_src, var_src;
  logic [DEN_W-1:0]   den;
  logic [MUL_B_W-1:0] diff;
  logic [GAIN_W-1:0]  gain_q, quo;
  logic               div_done;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [EST_SUM_W-1:0]      est_sum;
  logic [DATA_W-1:0]         est_new, var_new;

  logic in_accept, out_free;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctl.idle;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= Q_RESET;
      measure_noise <= ONE_VAL;
      init_estimate <= '0;
      init_variance <= ONE_VAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        REG_INIT_ESTIMATE: init_estimate <= cfg_data;
        REG_INIT_VARIANCE: init_variance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      meas     <= s_axis_tdata[DATA_W-1:0];
      ctrl_off <= s_axis_tdata[2*DATA_W-1:DATA_W];
      restart  <= s_axis_tuser;
    end
  end

  assign est_src = restart ? init_estimate : estimate_reg;
  assign var_src = restart ? init_variance : variance_reg;

  // Prediction step.
  always_ff @(posedge clk) begin
    if (ctl.prior_en) begin
      prior <= sat_s33({est_src[DATA_W-1], est_src} + {ctrl_off[DATA_W-1], ctrl_off});
      pvar  <= sat_u33({1'b0, var_src} + {1'b0, process_noise});
    end
  end

  assign den = {1'b0, pvar} + {1'b0, measure_noise};

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      diff <= MUL_B_W'(signed'(meas)) - MUL_B_W'(signed'(prior));
    end
    if (ctl.gain_en) begin
      gain_q <= quo;
    end
  end

  skf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (pvar),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // One multiplier serves the correction term and then the variance update.
  assign mul_a = ctl.mul_var_sel ? signed'({1'b0, GAIN_ONE - gain_q})
                                 : signed'({1'b0, gain_q});
  assign mul_b = ctl.mul_var_sel ? signed'(MUL_B_W'(pvar)) : signed'(diff);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // The arithmetic shift of the product rounds the correction toward minus infinity.
  assign est_sum = EST_SUM_W'(signed'(prior)) + EST_SUM_W'(signed'(prod[PROD_W-1:GAIN_BITS]));

  always_ff @(posedge clk) begin
    if (ctl.est_en) begin
      est_new <= sat_est(est_sum);
    end
  end

  assign var_new = (prod[PROD_W-1:DATA_W+GAIN_BITS] != '0) ? {DATA_W{1'b1}}
                 : prod[DATA_W+GAIN_BITS-1:GAIN_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg <= '0;
      variance_reg <= ONE_VAL;
    end else if (ctl.commit) begin
      estimate_reg <= est_new;
      variance_reg <= var_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      m_axis_tdata <= {(OUT_DATA_W-2*DATA_W-GAIN_W)'(0), gain_q, var_new, est_new};
    end
  end

  skf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .div_done  (div_done),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  `SKF_ASSERT(a_commit_shows, ctl.commit |=> m_axis_tvalid, "committed item not presented")
  `SKF_ASSERT(a_var_shrinks, ctl.commit |=> (variance_reg <= $past(pvar)), "variance grew in update")
  `SKF_NEVER(a_commit_overwrites, ctl.commit && m_axis_tvalid && !m_axis_tready, "result overwritten")

endmodule

// ----- verif/scalar_kalman_filter_test.sv -----
`timescale 1ns / 1ps

module scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int IDLE_PCT = 19;
  localparam int CYCLE_LIMIT = 250000;
  localparam int GAIN_SHIFT = 16;
  localparam longint GAIN_UNITY = 64'd1 << GAIN_SHIFT;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = '1;
  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] UNITY = DATA_W'(64'd1 << FRAC_BITS);

  typedef struct {
    logic [DATA_W-1:0] estimate;
    logic [DATA_W-1:0] variance;
    logic [GAIN_W-1:0] gain;
  } filter_out_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  // Filter state and registers as the block should hold them.
  logic [DATA_W-1:0] noise_q;
  logic [DATA_W-1:0] noise_r;
  logic [DATA_W-1:0] restart_estimate;
  logic [DATA_W-1:0] restart_variance;
  logic [DATA_W-1:0] held_estimate;
  logic [DATA_W-1:0] held_variance;

  filter_out_t pending_updates[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int receiver_hold_request = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  scalar_kalman_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items sent, %0d results pending", cycle_count,
               items_sent, pending_updates.size());
      $display("scalar_kalman_filter: mismatch");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] clip_signed(input longint v);
    logic [DATA_W-1:0] r;
    if (v > longint'(signed'(S32_MAX))) begin
      r = S32_MAX;
    end else if (v < longint'(signed'(S32_MIN))) begin
      r = S32_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] clip_unsigned(input longint v);
    return (v > longint'(U32_MAX)) ? U32_MAX : v[DATA_W-1:0];
  endfunction

  // One filter step on the held state; the held state takes the new values.
  function automatic filter_out_t kalman_update(input logic [DATA_W-1:0] z,
                                                input logic [DATA_W-1:0] u,
                                                input bit restart);
    longint prior;
    longint pvar;
    longint den;
    longint gain;
    longint est_sum;
    longint var_prod;
    filter_out_t r;
    if (restart) begin
      held_estimate = restart_estimate;
      held_variance = restart_variance;
    end
    prior = longint'(signed'(clip_signed(longint'(signed'(held_estimate))
                                         + longint'(signed'(u)))));
    pvar = longint'(clip_unsigned(longint'(held_variance) + longint'(noise_q)));
    den = pvar + longint'(noise_r);
    if (den == 0) begin
      gain = 0;
    end else begin
      gain = (pvar << GAIN_SHIFT) / den;
      if (gain > GAIN_UNITY) gain = GAIN_UNITY;
    end
    // Arithmetic shift of a signed value rounds the correction toward minus infinity.
    est_sum = prior + ((gain * (longint'(signed'(z)) - prior)) >>> GAIN_SHIFT);
    var_prod = ((GAIN_UNITY - gain) * pvar) >>> GAIN_SHIFT;
    held_estimate = clip_signed(est_sum);
    held_variance = clip_unsigned(var_prod);
    r.estimate = held_estimate;
    r.variance = held_variance;
    r.gain = gain[GAIN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("ERROR result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    filter_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("item with nothing pending", m_axis_tdata[DATA_W-1:0], 0);
      end else begin
        want = pending_updates.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.estimate)
          report_mismatch("new_estimate", m_axis_tdata[DATA_W-1:0], want.estimate);
        if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.variance)
          report_mismatch("new_variance", m_axis_tdata[2*DATA_W-1:DATA_W], want.variance);
        if (m_axis_tdata[2*DATA_W+GAIN_W-1:2*DATA_W] !== want.gain)
          report_mismatch("gain", m_axis_tdata[2*DATA_W+GAIN_W-1:2*DATA_W], want.gain);
        if (m_axis_tdata[OUT_DATA_W-1:2*DATA_W+GAIN_W] !== '0)
          report_mismatch("padding", m_axis_tdata[OUT_DATA_W-1:2*DATA_W+GAIN_W], 0);
      end
      results_seen++;
    end
  end

  // The receiver stalls at random, or for a whole stretch when one is requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold_request > 0) begin
        hold_left = receiver_hold_request;
        receiver_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Returns at the edge that accepts the item; tvalid stays high until the next call.
  task automatic send_item(input logic [DATA_W-1:0] z, input logic [DATA_W-1:0] u,
                           input bit restart);
    @(negedge clk);
    while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {u, z};
    s_axis_tuser <= restart;
    do @(posedge clk); while (!s_axis_tready);
    pending_updates.push_back(kalman_update(z, u, restart));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PROCESS_NOISE: noise_q = value;
      REG_MEASURE_NOISE: noise_r = value;
      REG_INIT_ESTIMATE: restart_estimate = value;
      REG_INIT_VARIANCE: restart_variance = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_signed_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom();
      1: begin
        v = $urandom_range(0, 32'h001F_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        case ($urandom_range(3))
          0: v = S32_MAX;
          1: v = S32_MIN;
          2: v = '0;
          default: v = U32_MAX;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h0000_FFFF);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_noise_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(4))
      0: v = $urandom();
      1: v = $urandom_range(0, 32'h0004_0000);
      2: begin
        case ($urandom_range(2))
          0: v = '0;
          1: v = U32_MAX;
          default: v = 32'd1;
        endcase
      end
      default: v = $urandom_range(0, 32'h0001_0000);
    endcase
    return v;
  endfunction

  task automatic test_reset_state();
    // First items run from the state left by reset, with default registers.
    send_item(UNITY, '0, 1'b0);
    send_item(S32_MAX, '0, 1'b0);
    send_item(S32_MIN, '0, 1'b0);
    send_item(U32_MAX, U32_MAX, 1'b0);
    send_item('0, '0, 1'b1);
  endtask

  task automatic test_corner_cases();
    // Prior estimate overflows in both directions.
    wait_drained();
    write_register(REG_INIT_ESTIMATE, S32_MAX);
    send_item(S32_MIN, S32_MAX, 1'b1);
    send_item(S32_MAX, S32_MAX, 1'b0);
    wait_drained();
    write_register(REG_INIT_ESTIMATE, S32_MIN);
    send_item(S32_MAX, S32_MIN, 1'b1);
    send_item(32'h0001_2345, S32_MIN, 1'b0);

    // Zero noise and zero variance: the denominator is zero and the gain is zero.
    wait_drained();
    write_register(REG_PROCESS_NOISE, '0);
    write_register(REG_MEASURE_NOISE, '0);
    write_register(REG_INIT_VARIANCE, '0);
    send_item(32'h1234_5678, 32'hFFFF_0000, 1'b1);
    send_item(S32_MIN, '0, 1'b0);

    // Saturated prior variance and a huge denominator.
    wait_drained();
    write_register(REG_PROCESS_NOISE, U32_MAX);
    write_register(REG_MEASURE_NOISE, U32_MAX);
    write_register(REG_INIT_VARIANCE, U32_MAX);
    write_register(REG_INIT_ESTIMATE, '0);
    send_item(S32_MAX, '0, 1'b1);
    send_item(S32_MIN, '0, 1'b0);
    send_item(32'hFFFF_FFFE, 32'd1, 1'b0);

    // Zero measurement noise gives a gain of exactly one.
    wait_drained();
    write_register(REG_MEASURE_NOISE, '0);
    write_register(REG_PROCESS_NOISE, 32'd655);
    write_register(REG_INIT_VARIANCE, UNITY);
    send_item(S32_MIN, S32_MAX, 1'b1);
    send_item(32'hFFFF_8000, '0, 1'b0);

    // Writes to indexes with no register behind them change nothing.
    wait_drained();
    write_register(REG_MEASURE_NOISE, UNITY);
    write_register(REG_UNUSED_LOW, U32_MAX);
    write_register(REG_UNUSED_HIGH, 32'h5A5A_5A5A);
    send_item(32'hFFFF_FFFF, '0, 1'b1);
    send_item(32'h0000_0001, '0, 1'b0);
    send_item(32'h8000_0001, 32'h7FFF_FFFE, 1'b0);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      write_register(REG_PROCESS_NOISE, pick_noise_value());
      write_register(REG_MEASURE_NOISE, pick_noise_value());
      write_register(REG_INIT_ESTIMATE, pick_signed_value());
      write_register(REG_INIT_VARIANCE, pick_noise_value());
      // One phase runs with neither side idling.
      sender_idles = (phase != 2);
      receiver_idles = (phase != 2);
      send_item(pick_signed_value(), pick_signed_value(), 1'b1);
      repeat (74) send_item(pick_signed_value(), pick_signed_value(),
                            $urandom_range(9) == 0);
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_output_backpressure();
    // The receiver stops for a long stretch while items keep coming, so the
    // output register and the commit stage fill and the input stalls.
    send_item(pick_signed_value(), pick_signed_value(), 1'b0);
    receiver_hold_request = 400;
    repeat (6) send_item(pick_signed_value(), pick_signed_value(), $urandom_range(3) == 0);
  endtask

  task automatic test_sender_pause();
    repeat (10) send_item(pick_signed_value(), pick_signed_value(), $urandom_range(5) == 0);
    wait_drained();
    repeat (10) send_item(pick_signed_value(), pick_signed_value(), $urandom_range(5) == 0);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    noise_q = UNITY / 100;
    noise_r = UNITY;
    restart_estimate = '0;
    restart_variance = UNITY;
    held_estimate = '0;
    held_variance = UNITY;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_corner_cases();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("scalar_kalman_filter: match");
    end else begin
      $display("scalar_kalman_filter: mismatch");
    end
    $finish;
  end

endmodule
